// ===== rtl/rrts_pkg.sv =====
// shared types and constants for the round-robin task scheduler
// used by rrts_ctrl, rrts_dp and round_robin_task_scheduler; no dependencies
package rrts_pkg;

   localparam int FUNC_W   = 3;
   localparam int TASK_W   = 4;
   localparam int STATE_W  = 2;
   localparam int STATUS_W = 2;
   localparam int SLICE_W  = 8;
   localparam int CSR_IDX_W = 1;

   // item function codes
   localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_YIELD  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SET    = 3'd4;

   // slot states
   localparam logic [STATE_W-1:0] TS_READY   = 2'd0;
   localparam logic [STATE_W-1:0] TS_RUNNING = 2'd1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PROTECTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_PRESENT   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT    = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_SLICE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED    = 1'd1;

   localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;

   // controller to datapath
   typedef struct packed {
      logic                accept;
      logic                tick_dec;
      logic                walk_init;
      logic                walk_step;
      logic                ptr_clear;
      logic                demote;
      logic                promote;
      logic                set_state;
      logic                link_tail;
      logic                link_new;
      logic                unlink;
      logic                set_status;
      logic [STATUS_W-1:0] status_code;
      logic                publish;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              enabled;
      logic              slice_low;
      logic              id_bad;
      logic              id_protected;
      logic              id_in_ring;
      logic              ptr_eligible;
      logic              ptr_is_run;
      logic              next_is_start;
      logic              next_is_zero;
      logic              next_is_id;
      logic              rsp_busy;
   } dp_stat_type;

endpackage

// ===== rtl/rrts_ctrl.sv =====
// sequencing state machine of the round-robin task scheduler
// depends on rrts_pkg; drives rrts_dp through ctrl_cmd_type
module rrts_ctrl
   import rrts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_EXEC    = 4'd1;
   localparam logic [3:0] S_WALK    = 4'd2;
   localparam logic [3:0] S_SWITCH  = 4'd3;
   localparam logic [3:0] S_PROMOTE = 4'd4;
   localparam logic [3:0] S_TAIL    = 4'd5;
   localparam logic [3:0] S_LINK    = 4'd6;
   localparam logic [3:0] S_PRED    = 4'd7;
   localparam logic [3:0] S_UNLINK  = 4'd8;
   localparam logic [3:0] S_DONE    = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (stat.func)
               FUNC_TICK: begin
                  if (stat.enabled) begin
                     cmd.tick_dec = 1'b1;
                     if (stat.slice_low) begin
                        cmd.walk_init = 1'b1;
                        state_in      = S_WALK;
                     end
                  end
               end
               FUNC_YIELD: begin
                  cmd.walk_init = 1'b1;
                  state_in      = S_WALK;
               end
               FUNC_ADD: begin
                  if (stat.id_bad) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_PROTECTED;
                  end else if (stat.id_in_ring) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_PRESENT;
                  end else begin
                     cmd.ptr_clear = 1'b1;
                     state_in      = S_TAIL;
                  end
               end
               FUNC_REMOVE: begin
                  if (stat.id_bad || stat.id_protected) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_PROTECTED;
                  end else if (!stat.id_in_ring) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_ABSENT;
                  end else begin
                     cmd.ptr_clear = 1'b1;
                     state_in      = S_PRED;
                  end
               end
               FUNC_SET: begin
                  if (stat.id_bad) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_PROTECTED;
                  end else begin
                     cmd.set_state = 1'b1;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_WALK: begin
            if (stat.ptr_eligible) begin
               state_in = S_SWITCH;
            end else if (stat.next_is_start) begin
               state_in = S_DONE;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         S_SWITCH: begin
            if (stat.ptr_is_run) begin
               state_in = S_DONE;
            end else begin
               cmd.demote = 1'b1;
               state_in   = S_PROMOTE;
            end
         end
         S_PROMOTE: begin
            cmd.promote = 1'b1;
            state_in    = S_DONE;
         end
         S_TAIL: begin
            if (stat.next_is_zero) begin
               cmd.link_tail = 1'b1;
               state_in      = S_LINK;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         S_LINK: begin
            cmd.link_new = 1'b1;
            state_in     = S_DONE;
         end
         S_PRED: begin
            if (stat.next_is_id) begin
               state_in = S_UNLINK;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         S_UNLINK: begin
            cmd.unlink = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/rrts_dp.sv =====
// datapath of the round-robin task scheduler: ring links, slot states, slice
// counter, config registers and result register; depends on rrts_pkg
module rrts_dp
   import rrts_pkg::*;
#(
   parameter int MAX_TASKS = 16
)(
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   output dp_stat_type          stat,
   input  logic [FUNC_W-1:0]    req_func,
   input  logic [TASK_W-1:0]    req_task_id,
   input  logic [STATE_W-1:0]   req_task_state,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SLICE_W-1:0]   csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_switched,
   output logic [TASK_W-1:0]    rsp_current_task,
   output logic [TASK_W-1:0]    rsp_previous_task,
   output logic [STATUS_W-1:0]  rsp_status
);

   localparam int IDX_W = $clog2(MAX_TASKS);

   // config
   logic [SLICE_W-1:0] time_slice_ff;
   logic               enabled_ff;

   // scheduler state
   logic [IDX_W-1:0]   ring_next_ff [MAX_TASKS];
   logic [STATE_W-1:0] slot_state_ff [MAX_TASKS];
   logic [MAX_TASKS-1:0] in_ring_ff;
   logic [IDX_W-1:0]   running_ff;
   logic [SLICE_W-1:0] slice_left_ff;
   logic [SLICE_W-1:0] slice_left_in;

   // item being worked on
   logic [FUNC_W-1:0]   func_ff;
   logic [TASK_W-1:0]   id_ff;
   logic [STATE_W-1:0]  tstate_ff;
   logic [IDX_W-1:0]    prev_ff;
   logic                sw_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [IDX_W-1:0]    ptr_ff;
   logic [IDX_W-1:0]    start_ff;

   // result word
   logic                rsp_valid_ff;
   logic                rsp_sw_ff;
   logic [TASK_W-1:0]   rsp_cur_ff;
   logic [TASK_W-1:0]   rsp_prev_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic [IDX_W-1:0]   id_idx;
   logic [IDX_W-1:0]   nx_raddr;
   logic [IDX_W-1:0]   rd_next;
   logic [IDX_W-1:0]   st_raddr;
   logic [STATE_W-1:0] rd_state;
   logic               nx_we;
   logic [IDX_W-1:0]   nx_waddr;
   logic [IDX_W-1:0]   nx_wdata;
   logic               st_we;
   logic [IDX_W-1:0]   st_waddr;
   logic [STATE_W-1:0] st_wdata;

   assign id_idx = IDX_W'(id_ff);

   // one read address per store and cycle
   assign nx_raddr = cmd.walk_init ? running_ff : (cmd.unlink ? id_idx : ptr_ff);
   assign rd_next  = ring_next_ff[nx_raddr];
   assign st_raddr = cmd.demote ? running_ff : ptr_ff;
   assign rd_state = slot_state_ff[st_raddr];

   always_comb begin
      stat.func          = func_ff;
      stat.enabled       = enabled_ff;
      stat.slice_low     = (slice_left_ff <= SLICE_W'(1));
      stat.id_bad        = (int'(id_ff) >= MAX_TASKS);
      stat.id_protected  = (id_idx == '0) || (id_idx == prev_ff);
      stat.id_in_ring    = in_ring_ff[id_idx];
      stat.ptr_eligible  = (rd_state == TS_READY) || (rd_state == TS_RUNNING);
      stat.ptr_is_run    = (ptr_ff == running_ff);
      stat.next_is_start = (rd_next == start_ff);
      stat.next_is_zero  = (rd_next == '0);
      stat.next_is_id    = (rd_next == id_idx);
      stat.rsp_busy      = rsp_valid_ff && rsp_stall;
   end

   // link write port
   always_comb begin
      nx_we    = 1'b0;
      nx_waddr = ptr_ff;
      nx_wdata = id_idx;
      if (cmd.link_tail) begin
         nx_we = 1'b1;
      end else if (cmd.link_new) begin
         nx_we    = 1'b1;
         nx_waddr = id_idx;
         nx_wdata = '0;
      end else if (cmd.unlink) begin
         nx_we    = 1'b1;
         nx_wdata = rd_next;
      end
   end

   // slot state write port
   always_comb begin
      st_we    = 1'b0;
      st_waddr = id_idx;
      st_wdata = tstate_ff;
      if (cmd.set_state || cmd.link_tail) begin
         st_we = 1'b1;
      end else if (cmd.demote) begin
         st_we    = (rd_state == TS_RUNNING);
         st_waddr = running_ff;
         st_wdata = TS_READY;
      end else if (cmd.promote) begin
         st_we    = 1'b1;
         st_waddr = ptr_ff;
         st_wdata = TS_RUNNING;
      end
   end

   always_comb begin
      slice_left_in = slice_left_ff;
      if (cmd.promote) begin
         slice_left_in = time_slice_ff;
      end else if (cmd.tick_dec && (slice_left_ff != '0)) begin
         slice_left_in = slice_left_ff - SLICE_W'(1);
      end
   end

   // only slot 0 has a defined link after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_next_ff[0] <= '0;
      end else if (nx_we) begin
         ring_next_ff[nx_waddr] <= nx_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            slot_state_ff[i] <= (i == 0) ? TS_RUNNING : TS_READY;
         end
      end else if (st_we) begin
         slot_state_ff[st_waddr] <= st_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ring_ff    <= MAX_TASKS'(1);
         running_ff    <= '0;
         slice_left_ff <= SLICE_RESET;
         time_slice_ff <= SLICE_RESET;
         enabled_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slice_left_ff <= slice_left_in;
         if (cmd.link_tail) begin
            in_ring_ff[id_idx] <= 1'b1;
         end else if (cmd.unlink) begin
            in_ring_ff[id_idx] <= 1'b0;
         end
         if (cmd.promote) begin
            running_ff <= ptr_ff;
         end
         if (csr_write) begin
            case (csr_index)
               CSR_TIME_SLICE: time_slice_ff <= csr_data;
               CSR_ENABLED:    enabled_ff    <= csr_data[0];
               default:        enabled_ff    <= enabled_ff;
            endcase
         end
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff   <= req_func;
         id_ff     <= req_task_id;
         tstate_ff <= req_task_state;
         prev_ff   <= running_ff;
         sw_ff     <= 1'b0;
         status_ff <= STATUS_OK;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status_code;
      end
      if (cmd.promote) begin
         sw_ff <= 1'b1;
      end
      if (cmd.walk_init) begin
         ptr_ff   <= rd_next;
         start_ff <= rd_next;
      end else if (cmd.walk_step) begin
         ptr_ff <= rd_next;
      end else if (cmd.ptr_clear) begin
         ptr_ff <= '0;
      end
      if (cmd.publish) begin
         rsp_sw_ff     <= sw_ff;
         rsp_cur_ff    <= TASK_W'(running_ff);
         rsp_prev_ff   <= TASK_W'(prev_ff);
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_switched      = rsp_sw_ff;
   assign rsp_current_task  = rsp_cur_ff;
   assign rsp_previous_task = rsp_prev_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

// ===== rtl/round_robin_task_scheduler.sv =====
// round-robin time-slice task scheduler, top level
// depends on rrts_pkg, rrts_ctrl and rrts_dp
//
// usage
// - req channel: one word per event (tick, yield, add, remove, set state),
//   taken when req_valid is high and req_stall is low
// - rsp channel: exactly one word per req word, in order, taken when
//   rsp_valid is high and rsp_stall is low
// - csr port: csr_write with csr_index 0 writes time_slice, index 1 writes
//   enabled; write only while no word is in flight
// - one word is worked on at a time; a plain tick, set state or refused
//   word goes straight from decode to the result step
// - yield or slice expiry: a ring walk, then a switch check when the walk
//   stops on a ready or running slot, and demote and promote steps when
//   the task changes; the walk reads one ring link per cycle, so it reads
//   at most MAX_TASKS links
// - add: tail search, one link per cycle; remove: predecessor search
// - req_stall is high from accept until the result word is loaded into
//   the output register; the next word is taken while that result waits
// - a stalled receiver holds the result word; the block then waits with
//   the next finished result until the output register frees up
// - reset (synchronous, active high): slot 0 alone in the ring and
//   running, time_slice 10, ticks disabled, both channels empty; no
//   clearing pass
module round_robin_task_scheduler
   import rrts_pkg::*;
#(
   parameter int MAX_TASKS = 16
)(
   input  logic                 clock,
   input  logic                 reset,
   // event words
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [FUNC_W-1:0]    req_func,
   input  logic [TASK_W-1:0]    req_task_id,
   input  logic [STATE_W-1:0]   req_task_state,
   // result words
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_switched,
   output logic [TASK_W-1:0]    rsp_current_task,
   output logic [TASK_W-1:0]    rsp_previous_task,
   output logic [STATUS_W-1:0]  rsp_status,
   // configuration writes
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SLICE_W-1:0]   csr_data
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // sequencer: decode, ring walks, switch steps, result hand-off
   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // ring links, slot states, slice counter, config and result register
   rrts_dp #(
      .MAX_TASKS (MAX_TASKS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_func          (req_func),
      .req_task_id       (req_task_id),
      .req_task_state    (req_task_state),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_switched      (rsp_switched),
      .rsp_current_task  (rsp_current_task),
      .rsp_previous_task (rsp_previous_task),
      .rsp_status        (rsp_status)
   );

endmodule
